// ===== rtl/core/rci_pkg.sv =====
package rci_pkg;

  // field and register widths
  localparam int DATA_W    = 32;
  localparam int RAD_W     = 31;
  localparam int CFG_IDX_W = 2;

  // internal widths, all exact for any input pattern
  localparam int DIFF_W  = DATA_W + 1;       // origin minus centre
  localparam int A_W     = 2 * DATA_W;       // dir_x^2 + dir_y^2, unsigned
  localparam int H_W     = 2 * DATA_W + 2;   // half of b
  localparam int C_W     = 2 * DIFF_W + 1;   // dx^2 + dy^2 - r^2
  localparam int PROD2_W = 2 * H_W;          // h*h and a*c
  localparam int DISC_W  = PROD2_W + 1;
  localparam int ROOT_W  = PROD2_W / 2;      // floor root of a positive discriminant
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int N_W     = ROOT_W + 2;       // -h -/+ root
  localparam int NUM_W   = DATA_W + N_W;     // dir times (-h -/+ root)
  localparam int Q_W     = DATA_W + 2;       // quotient bits kept before saturating
  localparam int SUM_W   = Q_W + 2;

  // split of wide products into 32 by 32 pieces
  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 4;
  localparam int LANES   = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  // register reset values
  localparam logic [DATA_W-1:0] CENTER_X_RST = 32'd2621440;
  localparam logic [DATA_W-1:0] CENTER_Y_RST = 32'd655360;
  localparam logic [RAD_W-1:0]  RADIUS_RST   = 31'd32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_x;
    logic signed [DATA_W-1:0] origin_y;
    logic signed [DATA_W-1:0] origin_z;
    logic signed [DATA_W-1:0] dir_x;
    logic signed [DATA_W-1:0] dir_y;
    logic signed [DATA_W-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] near_x;
    logic signed [DATA_W-1:0] near_y;
    logic signed [DATA_W-1:0] near_z;
    logic signed [DATA_W-1:0] far_x;
    logic signed [DATA_W-1:0] far_y;
    logic signed [DATA_W-1:0] far_z;
  } res_t;

endpackage

// ===== rtl/core/rci_if.sv =====
interface rci_ray_if import rci_pkg::*; ();
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rci_res_if import rci_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rci_cfg_if import rci_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/rci_mul.sv =====
module rci_mul import rci_pkg::*; #(
  parameter int OPA_W = DATA_W,
  parameter int OPB_W = DATA_W
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [OPA_W-1:0]        opa,
  input  logic signed [OPB_W-1:0]        opb,
  output logic signed [OPA_W+OPB_W-1:0]  prod
);

  localparam int P_W   = OPA_W + OPB_W;
  localparam int NA    = (OPA_W + LIMB_W - 1) / LIMB_W;
  localparam int NB    = (OPB_W + LIMB_W - 1) / LIMB_W;
  localparam int ACC_W = (NA + NB) * LIMB_W;

  logic [NA*LIMB_W-1:0]  mag_a;
  logic [NB*LIMB_W-1:0]  mag_b;
  logic                  sgn1, sgn2, sgn3;
  logic [2*LIMB_W-1:0]   pp [NA][NB];
  logic [ACC_W-1:0]      acc;
  logic [P_W-1:0]        mag_p;

  // stage 1: magnitudes and product sign
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= (NA*LIMB_W)'($unsigned(opa[OPA_W-1] ? -opa : opa));
      mag_b <= (NB*LIMB_W)'($unsigned(opb[OPB_W-1] ? -opb : opb));
      sgn1  <= opa[OPA_W-1] ^ opb[OPB_W-1];
    end
  end

  // stage 2: 32 by 32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= (2*LIMB_W)'(mag_a[i*LIMB_W +: LIMB_W]) *
                      (2*LIMB_W)'(mag_b[j*LIMB_W +: LIMB_W]);
        end
      end
      sgn2 <= sgn1;
    end
  end

  // stage 3: sum of the shifted partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACC_W'(pp[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_p <= acc[P_W-1:0];
      sgn3  <= sgn2;
    end
  end

  // stage 4: apply the sign
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= sgn3 ? -$signed(mag_p) : $signed(mag_p);
    end
  end

endmodule

// ===== rtl/core/rci_div.sv =====
module rci_div import rci_pkg::*; #(
  parameter int LN = LANES,
  parameter int NW = NUM_W,
  parameter int DW = A_W,
  parameter int QW = Q_W
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num [LN],
  input  logic [DW-1:0]        den,
  output logic [QW-1:0]        quo [LN],
  output logic                 neg [LN],
  output logic                 ovf [LN]
);

  localparam int HI_W = NW - QW;

  logic [NW-1:0] mag  [LN];
  logic          neg0 [LN];
  logic [DW-1:0] den0;

  logic [DW-1:0] rem_s [QW+1][LN];
  logic [QW-1:0] lo_s  [QW+1][LN];
  logic [QW-1:0] q_s   [QW+1][LN];
  logic          neg_s [QW+1][LN];
  logic          ovf_s [QW+1][LN];
  logic [DW-1:0] den_s [QW+1];

  logic [DW:0]   cur  [QW][LN];
  logic          take [QW][LN];

  // magnitude of the numerator, sign kept for the end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LN; l++) begin
        mag[l]  <= $unsigned(num[l][NW-1] ? -num[l] : num[l]);
        neg0[l] <= num[l][NW-1];
      end
      den0 <= den;
    end
  end

  // high part against the divisor: quotient too large for the low bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LN; l++) begin
        ovf_s[0][l] <= mag[l][NW-1:QW] >= HI_W'(den0);
        rem_s[0][l] <= (mag[l][NW-1:QW] >= HI_W'(den0)) ? '0 : mag[l][QW+DW-1:QW];
        lo_s[0][l]  <= mag[l][QW-1:0];
        q_s[0][l]   <= '0;
        neg_s[0][l] <= neg0[l];
      end
      den_s[0] <= den0;
    end
  end

  // one quotient bit a stage
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < LN; l++) begin
        cur[k][l]  = {rem_s[k][l], lo_s[k][l][QW-1]};
        take[k][l] = cur[k][l] >= {1'b0, den_s[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        for (int l = 0; l < LN; l++) begin
          rem_s[k+1][l] <= take[k][l] ? DW'(cur[k][l] - {1'b0, den_s[k]})
                                      : cur[k][l][DW-1:0];
          lo_s[k+1][l]  <= lo_s[k][l] << 1;
          q_s[k+1][l]   <= {q_s[k][l][QW-2:0], take[k][l]};
          neg_s[k+1][l] <= neg_s[k][l];
          ovf_s[k+1][l] <= ovf_s[k][l];
        end
        den_s[k+1] <= den_s[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      quo[l] = q_s[QW][l];
      neg[l] = neg_s[QW][l];
      ovf[l] = ovf_s[QW][l];
    end
  end

endmodule

// ===== rtl/core/ray_cylinder_intersect.sv =====
// channel  | modport | payload                               | transaction when
// ---------+---------+---------------------------------------+------------------------
// ray      | sink    | origin_x/y/z, dir_x/y/z (ray_t)       | ray.valid & ray.ready
// res      | source  | hit, near_x/y/z, far_x/y/z (res_t)    | res.valid & res.ready
// cfg      | sink    | index, wdata                          | cfg.valid & cfg.ready
//
// one ray is taken every cycle while res is not stalled
// most of the pipeline length comes from the 66-stage square root and the 36-stage dividers
// rst is synchronous: clears the valid bits and loads the cylinder registers
// a stall on res freezes the whole pipeline, cfg is always ready
module ray_cylinder_intersect import rci_pkg::*; (
  input logic         clk,
  input logic         rst,
  rci_ray_if.sink     ray,
  rci_res_if.source   res,
  rci_cfg_if.sink     cfg
);

  // stage times counted from the transaction
  localparam int T_A  = 1;
  localparam int T_M1 = T_A + MUL_LAT;
  localparam int T_B  = T_M1 + 1;
  localparam int T_M2 = T_B + MUL_LAT;
  localparam int T_C  = T_M2 + 1;
  localparam int T_S  = T_C + ROOT_W;
  localparam int T_D  = T_S + 1;
  localparam int T_M3 = T_D + MUL_LAT;
  localparam int T_V  = T_M3 + Q_W + 2;

  localparam int RAY_DL = T_S - T_A;
  localparam int AH_DL  = T_S - T_B;
  localparam int HIT_DL = T_V - T_C;
  localparam int ORG_DL = T_V - T_D;

  logic [DATA_W-1:0] center_x, center_y;
  logic [RAD_W-1:0]  radius;

  logic en;
  logic out_valid;
  res_t res_q;

  // cylinder registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_X_RST;
      center_y <= CENTER_Y_RST;
      radius   <= RADIUS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: center_x <= cfg.wdata;
        REG_CENTER_Y: center_y <= cfg.wdata;
        REG_RADIUS:   radius   <= cfg.wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can move
  assign en        = !out_valid || res.ready;
  assign ray.ready = en;

  // valid bits
  logic vld [T_V];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < T_V; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= ray.valid;
      for (int i = 1; i < T_V; i++) vld[i] <= vld[i-1];
    end
  end

  // stage A: register the ray and the offsets from the axis
  ray_t                     ray_a;
  logic signed [DIFF_W-1:0] diff_x, diff_y;

  always_ff @(posedge clk) begin
    if (en) begin
      ray_a  <= ray.data;
      diff_x <= $signed({ray.data.origin_x[DATA_W-1], ray.data.origin_x}) -
                $signed({center_x[DATA_W-1], center_x});
      diff_y <= $signed({ray.data.origin_y[DATA_W-1], ray.data.origin_y}) -
                $signed({center_y[DATA_W-1], center_y});
    end
  end

  // first products
  logic signed [2*DATA_W-1:0]     p_xx, p_yy, p_rr;
  logic signed [DATA_W+DIFF_W-1:0] p_hx, p_hy;
  logic signed [2*DIFF_W-1:0]     p_dxx, p_dyy;

  rci_mul #(.OPA_W(DATA_W), .OPB_W(DATA_W)) u_mul_xx (
    .clk(clk), .en(en), .opa(ray_a.dir_x), .opb(ray_a.dir_x), .prod(p_xx));
  rci_mul #(.OPA_W(DATA_W), .OPB_W(DATA_W)) u_mul_yy (
    .clk(clk), .en(en), .opa(ray_a.dir_y), .opb(ray_a.dir_y), .prod(p_yy));
  rci_mul #(.OPA_W(DATA_W), .OPB_W(DIFF_W)) u_mul_hx (
    .clk(clk), .en(en), .opa(ray_a.dir_x), .opb(diff_x), .prod(p_hx));
  rci_mul #(.OPA_W(DATA_W), .OPB_W(DIFF_W)) u_mul_hy (
    .clk(clk), .en(en), .opa(ray_a.dir_y), .opb(diff_y), .prod(p_hy));
  rci_mul #(.OPA_W(DIFF_W), .OPB_W(DIFF_W)) u_mul_dxx (
    .clk(clk), .en(en), .opa(diff_x), .opb(diff_x), .prod(p_dxx));
  rci_mul #(.OPA_W(DIFF_W), .OPB_W(DIFF_W)) u_mul_dyy (
    .clk(clk), .en(en), .opa(diff_y), .opb(diff_y), .prod(p_dyy));
  rci_mul #(.OPA_W(DATA_W), .OPB_W(DATA_W)) u_mul_rr (
    .clk(clk), .en(en), .opa($signed({1'b0, radius})), .opb($signed({1'b0, radius})),
    .prod(p_rr));

  // stage B: quadratic coefficients
  logic [A_W-1:0]        a_b;
  logic signed [H_W-1:0] h_b;
  logic signed [C_W-1:0] c_b;
  logic                  anz_b;

  always_ff @(posedge clk) begin
    if (en) begin
      a_b   <= A_W'($unsigned(p_xx)) + A_W'($unsigned(p_yy));
      anz_b <= (A_W'($unsigned(p_xx)) + A_W'($unsigned(p_yy))) != '0;
      h_b   <= H_W'(p_hx) + H_W'(p_hy);
      c_b   <= C_W'(p_dxx) + C_W'(p_dyy) - C_W'(p_rr);
    end
  end

  // second products
  logic signed [PROD2_W-1:0] p_hh, p_ac;

  rci_mul #(.OPA_W(H_W), .OPB_W(H_W)) u_mul_hh (
    .clk(clk), .en(en), .opa(h_b), .opb(h_b), .prod(p_hh));
  rci_mul #(.OPA_W(A_W+1), .OPB_W(C_W)) u_mul_ac (
    .clk(clk), .en(en), .opa($signed({1'b0, a_b})), .opb(c_b), .prod(p_ac));

  // side data that runs alongside the arithmetic
  ray_t                  ray_dl [RAY_DL];
  logic [A_W-1:0]        a_dl   [AH_DL];
  logic signed [H_W-1:0] h_dl   [AH_DL];
  logic                  anz_dl [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ray_dl[0] <= ray_a;
      for (int i = 1; i < RAY_DL; i++) ray_dl[i] <= ray_dl[i-1];
      a_dl[0] <= a_b;
      h_dl[0] <= h_b;
      for (int i = 1; i < AH_DL; i++) begin
        a_dl[i] <= a_dl[i-1];
        h_dl[i] <= h_dl[i-1];
      end
      anz_dl[0] <= anz_b;
      for (int i = 1; i < MUL_LAT; i++) anz_dl[i] <= anz_dl[i-1];
    end
  end

  // stage C: discriminant and hit decision
  logic signed [DISC_W-1:0] disc;
  logic                     hit_c;

  assign disc = DISC_W'(p_hh) - DISC_W'(p_ac);

  logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [SQ_W-1:0]   sq_x    [ROOT_W+1];
  logic [REM_W+1:0]  sq_cur  [ROOT_W];
  logic [REM_W+1:0]  sq_try  [ROOT_W];
  logic              sq_take [ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_c      <= anz_dl[MUL_LAT-1] && !disc[DISC_W-1] && (disc != '0);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_x[0]    <= disc[SQ_W-1:0];
    end
  end

  // floor square root, one root bit a stage
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      sq_cur[k]  = {sq_rem[k], sq_x[k][SQ_W-1 -: 2]};
      sq_try[k]  = (REM_W+2)'({sq_root[k], 2'b01});
      sq_take[k] = sq_cur[k] >= sq_try[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        sq_rem[k+1]  <= sq_take[k] ? REM_W'(sq_cur[k] - sq_try[k]) : REM_W'(sq_cur[k]);
        sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], sq_take[k]};
        sq_x[k+1]    <= sq_x[k] << 2;
      end
    end
  end

  logic hit_dl [HIT_DL];

  always_ff @(posedge clk) begin
    if (en) begin
      hit_dl[0] <= hit_c;
      for (int i = 1; i < HIT_DL; i++) hit_dl[i] <= hit_dl[i-1];
    end
  end

  // stage D: the two root numerators
  logic signed [N_W-1:0]    h_ext, s_ext;
  logic signed [N_W-1:0]    nn_d, nf_d;
  logic signed [DATA_W-1:0] dir_d [3];
  logic signed [DATA_W-1:0] org_d [3];
  logic [A_W-1:0]           a_d;

  assign h_ext = {{(N_W-H_W){h_dl[AH_DL-1][H_W-1]}}, h_dl[AH_DL-1]};
  assign s_ext = $signed({{(N_W-ROOT_W){1'b0}}, sq_root[ROOT_W]});

  always_ff @(posedge clk) begin
    if (en) begin
      nn_d     <= -h_ext - s_ext;
      nf_d     <= s_ext - h_ext;
      a_d      <= a_dl[AH_DL-1];
      dir_d[0] <= ray_dl[RAY_DL-1].dir_x;
      dir_d[1] <= ray_dl[RAY_DL-1].dir_y;
      dir_d[2] <= ray_dl[RAY_DL-1].dir_z;
      org_d[0] <= ray_dl[RAY_DL-1].origin_x;
      org_d[1] <= ray_dl[RAY_DL-1].origin_y;
      org_d[2] <= ray_dl[RAY_DL-1].origin_z;
    end
  end

  // direction times numerator, near lanes then far lanes
  logic signed [NUM_W-1:0] p_num [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_num
    rci_mul #(.OPA_W(DATA_W), .OPB_W(N_W)) u_mul_num (
      .clk (clk),
      .en  (en),
      .opa (dir_d[l % 3]),
      .opb ((l < 3) ? nn_d : nf_d),
      .prod(p_num[l])
    );
  end

  logic [A_W-1:0] a_dv [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      a_dv[0] <= a_d;
      for (int i = 1; i < MUL_LAT; i++) a_dv[i] <= a_dv[i-1];
    end
  end

  // divide by a, rounding toward zero
  logic [Q_W-1:0] quo   [LANES];
  logic           q_neg [LANES];
  logic           q_ovf [LANES];

  rci_div #(.LN(LANES), .NW(NUM_W), .DW(A_W), .QW(Q_W)) u_div (
    .clk(clk),
    .en (en),
    .num(p_num),
    .den(a_dv[MUL_LAT-1]),
    .quo(quo),
    .neg(q_neg),
    .ovf(q_ovf)
  );

  logic signed [DATA_W-1:0] org_dl [ORG_DL][3];

  always_ff @(posedge clk) begin
    if (en) begin
      org_dl[0] <= org_d;
      for (int i = 1; i < ORG_DL; i++) org_dl[i] <= org_dl[i-1];
    end
  end

  // stage E: add the origin and saturate
  logic signed [SUM_W-1:0]  q_ext [LANES];
  logic signed [SUM_W-1:0]  pt_sum [LANES];
  logic signed [DATA_W-1:0] pt [LANES];
  logic                     hit_v;
  res_t                     res_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_ext[l]  = $signed({{(SUM_W-Q_W){1'b0}}, quo[l]});
      pt_sum[l] = SUM_W'(org_dl[ORG_DL-1][l % 3]) + (q_neg[l] ? -q_ext[l] : q_ext[l]);
      if (q_ovf[l]) begin
        pt[l] = q_neg[l] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                         : $signed({1'b0, {(DATA_W-1){1'b1}}});
      end else if (pt_sum[l][SUM_W-1:DATA_W-1] == '0 ||
                   pt_sum[l][SUM_W-1:DATA_W-1] == '1) begin
        pt[l] = pt_sum[l][DATA_W-1:0];
      end else begin
        pt[l] = pt_sum[l][SUM_W-1] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                                   : $signed({1'b0, {(DATA_W-1){1'b1}}});
      end
    end
    hit_v = hit_dl[HIT_DL-1];
    res_next.hit    = hit_v;
    res_next.near_x = hit_v ? pt[0] : '0;
    res_next.near_y = hit_v ? pt[1] : '0;
    res_next.near_z = hit_v ? pt[2] : '0;
    res_next.far_x  = hit_v ? pt[3] : '0;
    res_next.far_y  = hit_v ? pt[4] : '0;
    res_next.far_z  = hit_v ? pt[5] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[T_V-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res_next;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = res_q;

endmodule

// ===== verif/tb_ray_cylinder_intersect.sv =====
module tb_ray_cylinder_intersect;
  import rci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PIPE_DRAIN = 140;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;

  rci_ray_if ray ();
  rci_res_if res ();
  rci_cfg_if cfg ();

  ray_cylinder_intersect dut (
    .clk (clk),
    .rst (rst),
    .ray (ray),
    .res (res),
    .cfg (cfg)
  );

  // cylinder settings as the block should hold them
  logic signed [DATA_W-1:0] axis_x;
  logic signed [DATA_W-1:0] axis_y;
  logic [RAD_W-1:0]         axis_r;

  ray_t   rays_to_send[$];
  res_t   hits_due[$];
  int     errors;
  int     rays_sent;
  int     hits_seen;
  int     misses_seen;
  longint cycles;
  bit     gaps_on;
  bit     stalls_on;
  int     gap_left;
  int     stall_left;
  bit     ray_taken;
  bit     res_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] clamp32(wide_t v);
    wide_t lo;
    wide_t hi;
    lo = -(wide_t'(1) <<< 31);
    hi = (wide_t'(1) <<< 31) - 1;
    if (v < lo) return {1'b1, {(DATA_W-1){1'b0}}};
    if (v > hi) return {1'b0, {(DATA_W-1){1'b1}}};
    return v[DATA_W-1:0];
  endfunction

  // exact intersection of one ray with the configured cylinder
  function automatic res_t cylinder_hit(ray_t r);
    res_t  o;
    wide_t org[3];
    wide_t dir[3];
    wide_t dx, dy, rr, qa, qh, qc, disc, root, cand, nn, nf;
    o = '0;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
    dx = org[0] - wide_t'(axis_x);
    dy = org[1] - wide_t'(axis_y);
    rr = wide_t'({1'b0, axis_r});
    qa = dir[0] * dir[0] + dir[1] * dir[1];
    qh = dir[0] * dx + dir[1] * dy;
    qc = dx * dx + dy * dy - rr * rr;
    disc = qh * qh - qa * qc;
    if (qa == 0 || disc <= 0) return o;
    // floor square root, bit by bit
    root = 0;
    for (int b = 80; b >= 0; b--) begin
      cand = root | (wide_t'(1) <<< b);
      if (cand * cand <= disc) root = cand;
    end
    nn = -qh - root;
    nf = -qh + root;
    o.hit    = 1'b1;
    o.near_x = clamp32(org[0] + (dir[0] * nn) / qa);
    o.near_y = clamp32(org[1] + (dir[1] * nn) / qa);
    o.near_z = clamp32(org[2] + (dir[2] * nn) / qa);
    o.far_x  = clamp32(org[0] + (dir[0] * nf) / qa);
    o.far_y  = clamp32(org[1] + (dir[1] * nf) / qa);
    o.far_z  = clamp32(org[2] + (dir[2] * nf) / qa);
    return o;
  endfunction

  // ray driver
  always @(negedge clk) begin
    if (rst) begin
      ray.valid <= 1'b0;
      ray.data  <= '0;
      gap_left  <= 0;
    end else if (ray.valid && !ray_taken) begin
      ray.valid <= 1'b1;
    end else if (gap_left > 0) begin
      ray.valid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (rays_to_send.size() > 0) begin
      ray.data  <= rays_to_send.pop_front();
      ray.valid <= 1'b1;
      gap_left  <= gaps_on ? $urandom_range(0, 11) : 0;
    end else begin
      ray.valid <= 1'b0;
    end
  end

  // result back-pressure, a drawn wait after each transaction
  always @(negedge clk) begin
    int idle_n;
    if (rst) begin
      res.ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (res_taken) begin
      idle_n = stalls_on ? $urandom_range(0, 11) : 0;
      if (idle_n > 0) begin
        res.ready  <= 1'b0;
        stall_left <= idle_n - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end else begin
      res.ready <= 1'b1;
    end
  end

  // monitor: record rays, check results, track settings
  always @(posedge clk) begin
    res_t got;
    res_t want;
    ray_taken <= ray.valid && ray.ready;
    res_taken <= res.valid && res.ready;
    cycles <= cycles + 1;
    if (rst) begin
      axis_x <= CENTER_X_RST;
      axis_y <= CENTER_Y_RST;
      axis_r <= RADIUS_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CENTER_X: axis_x <= cfg.wdata;
          REG_CENTER_Y: axis_y <= cfg.wdata;
          REG_RADIUS:   axis_r <= cfg.wdata[RAD_W-1:0];
          default: ;
        endcase
      end
      if (ray.valid && ray.ready) begin
        hits_due.push_back(cylinder_hit(ray.data));
        rays_sent <= rays_sent + 1;
      end
      if (res.valid && res.ready) begin
        got = res.data;
        if (hits_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = hits_due.pop_front();
          if (got.hit) hits_seen <= hits_seen + 1;
          else misses_seen <= misses_seen + 1;
          if (got !== want) begin
            $display("%0t: mismatch hit exp %0b act %0b", $time, want.hit, got.hit);
            $display("  near exp %h %h %h act %h %h %h", want.near_x, want.near_y,
                     want.near_z, got.near_x, got.near_y, got.near_z);
            $display("  far  exp %h %h %h act %h %h %h", want.far_x, want.far_y,
                     want.far_z, got.far_x, got.far_y, got.far_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // hold off until the pipeline has emptied
  task automatic drain();
    while (rays_to_send.size() > 0 || ray.valid || hits_due.size() > 0)
      @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic ray_t make_ray(logic [DATA_W-1:0] ox, logic [DATA_W-1:0] oy,
                                    logic [DATA_W-1:0] oz, logic [DATA_W-1:0] vx,
                                    logic [DATA_W-1:0] vy, logic [DATA_W-1:0] vz);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = vx;    r.dir_y = vy;    r.dir_z = vz;
    return r;
  endfunction

  // value of random magnitude, mostly small
  function automatic logic [DATA_W-1:0] scaled(int max_shift);
    int sh;
    logic [DATA_W-1:0] v;
    sh = $urandom_range(0, max_shift);
    v = $urandom & DATA_W'((64'd1 << sh) - 1);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // well-formed rays aimed near the axis, plus plain noise
  task automatic queue_random(int count);
    logic [DATA_W-1:0] span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        rays_to_send.push_back(make_ray($urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom));
      end else begin
        span = (axis_r == 0) ? 32'd65536 : {1'b0, axis_r} << $urandom_range(0, 2);
        rays_to_send.push_back(make_ray(
          axis_x + scaled(31) % (span | 1) + scaled(8),
          axis_y + scaled(31) % (span | 1) + scaled(8),
          scaled(31), scaled(31), scaled(31), scaled(31)));
      end
    end
  endtask

  task automatic run_phase(int count);
    gaps_on   = $urandom_range(0, 1);
    stalls_on = $urandom_range(0, 1);
    queue_random(count);
    drain();
  endtask

  localparam logic [DATA_W-1:0] MAXV = 32'h7fffffff;
  localparam logic [DATA_W-1:0] MINV = 32'h80000000;
  localparam logic [DATA_W-1:0] ONE  = 32'h00010000;

  initial begin
    errors = 0; rays_sent = 0; hits_seen = 0; misses_seen = 0; cycles = 0;
    gaps_on = 1'b0; stalls_on = 1'b0; ray_taken = 1'b0; res_taken = 1'b0;
    ray.valid = 1'b0; ray.data = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.wdata = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rays against the reset cylinder at (40, 10), radius 0.5
    rays_to_send.push_back(make_ray(0, 10 * ONE, 0, ONE, 0, ONE));          // crossing hit
    rays_to_send.push_back(make_ray(0, 10 * ONE + ONE / 2, 0, ONE, 0, 0)); // tangent
    rays_to_send.push_back(make_ray(0, 12 * ONE, 0, ONE, 0, 0));           // clean miss
    rays_to_send.push_back(make_ray(40 * ONE, 10 * ONE, 0, 0, 0, ONE));    // along the axis
    rays_to_send.push_back(make_ray(40 * ONE, 10 * ONE, 5 * ONE, 0, ONE, -ONE)); // from inside
    rays_to_send.push_back(make_ray(0, 10 * ONE, MAXV, ONE, 0, MAXV));     // z saturates
    rays_to_send.push_back(make_ray(MINV, MINV, MINV, MAXV, MAXV, MINV));
    rays_to_send.push_back(make_ray(MAXV, MAXV, MAXV, MINV, MINV, MAXV));
    rays_to_send.push_back(make_ray(MINV, 10 * ONE, 0, 1, 0, MINV));       // tiny direction
    rays_to_send.push_back(make_ray(0, 0, 0, MINV, MINV, MINV));
    rays_to_send.push_back(make_ray(80 * ONE, 10 * ONE, 0, -ONE, 0, 0));
    rays_to_send.push_back(make_ray(40 * ONE, 0, 0, 0, ONE, 3));
    rays_to_send.push_back(make_ray('0, '0, '0, '0, '0, '0));
    rays_to_send.push_back(make_ray('1, '1, '1, '1, '1, '1));
    drain();

    // random traffic through a range of cylinders
    run_phase(120);
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 0);
    write_reg(REG_RADIUS, 5 * ONE);
    write_reg(REG_UNUSED, $urandom);
    rays_to_send.push_back(make_ray(-10 * ONE, 0, 0, ONE, 0, 0));
    rays_to_send.push_back(make_ray(-10 * ONE, 5 * ONE, 0, ONE, 0, 0));
    run_phase(120);
    write_reg(REG_RADIUS, 0);
    rays_to_send.push_back(make_ray(-ONE, 0, 0, ONE, 0, ONE));
    run_phase(60);
    write_reg(REG_CENTER_X, MINV);
    write_reg(REG_CENTER_Y, MAXV);
    write_reg(REG_RADIUS, 32'h7fffffff);
    rays_to_send.push_back(make_ray(MAXV, MINV, 0, MINV, MAXV, ONE));
    run_phase(120);
    write_reg(REG_CENTER_X, MAXV);
    write_reg(REG_CENTER_Y, MINV);
    write_reg(REG_RADIUS, 32'hffffffff);
    run_phase(100);
    write_reg(REG_CENTER_X, $urandom);
    write_reg(REG_CENTER_Y, $urandom);
    write_reg(REG_RADIUS, $urandom_range(1, 1 << 22));
    run_phase(140);
    write_reg(REG_CENTER_X, 3 * ONE);
    write_reg(REG_CENTER_Y, -7 * ONE);
    write_reg(REG_RADIUS, 2 * ONE);
    run_phase(140);

    $display("sent %0d rays over seven cylinder settings, %0d hits and %0d misses checked",
             rays_sent, hits_seen, misses_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
